>>> src/hsl_to_rgb_converter_defines.svh
// Assertion macros shared by the HSL to RGB converter RTL.
// Depends on nothing; files that assert include it by name.
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check an implication on every clock outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence on the clock after its cause, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequence on the following clock, reset included.
`define ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`define ASSERT_ALWAYS_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/hsl2rgb_pkg.sv
// Types and constants of the HSL to RGB converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

    // One twelfth of the hue circle is SCALE units.
    localparam int SCALE      = 255;
    localparam int SCALE_SQ   = 65025;
    localparam int CIRCLE     = 3060;
    localparam int EDGE_LOW   = 765;
    localparam int EDGE_HIGH  = 2295;

    // Channel offsets in units of half a wedge.
    localparam logic [3:0] OFFSET_RED   = 4'd0;
    localparam logic [3:0] OFFSET_GREEN = 4'd8;
    localparam logic [3:0] OFFSET_BLUE  = 4'd4;

    // Register stages from input acceptance to output register.
    localparam int PIPE_DEPTH = 6;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } t_hsl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Clamped chroma weight, -255..255.
    typedef logic signed [8:0] t_cval;

endpackage

>>> src/hsl2rgb_hue_wedge.sv
// Hue wedge weight for one channel: folds hue plus offset onto the circle
// and clamps the triangle wave. Depends on hsl2rgb_pkg.
`timescale 1ns / 1ps

module hsl2rgb_hue_wedge
    import hsl2rgb_pkg::*;
(
    input  logic [7:0] i_hue,
    input  logic [3:0] i_offset,
    output t_cval      o_c
);

    logic [12:0]        sum;
    logic [11:0]        k;
    logic signed [12:0] rise;
    logic signed [12:0] fall;
    logic signed [12:0] low;

    always_comb begin
        // offset*255 + hue*12, below twice the circle for offsets up to 11
        sum = ({1'b0, i_offset, 8'd0} - {9'd0, i_offset})
            + {2'b0, i_hue, 3'd0} + {3'b0, i_hue, 2'd0};
        if (sum >= 13'(CIRCLE)) begin
            k = 12'(sum - 13'(CIRCLE));
        end else begin
            k = sum[11:0];
        end
        rise = $signed({1'b0, k}) - 13'sd765;
        fall = 13'sd2295 - $signed({1'b0, k});
        low  = (fall < rise) ? fall : rise;
        if (low > 13'sd255) begin
            o_c = 9'sd255;
        end else if (low < -13'sd255) begin
            o_c = -9'sd255;
        end else begin
            o_c = low[8:0];
        end
    end

endmodule

>>> src/hsl2rgb_chan.sv
// Per-channel back end: chroma product, subtraction from the lightness term
// and exact division by 65025 over four register stages. Depends on hsl2rgb_pkg.
`timescale 1ns / 1ps

module hsl2rgb_chan
    import hsl2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_cval       i_c,
    input  logic [14:0] i_sm,
    input  logic [23:0] i_lt,
    output logic [7:0]  o_value
);

    logic signed [24:0] r_p;
    logic signed [24:0] n_p;
    logic [23:0]        r_lt;
    logic [24:0]        r_num;
    logic [24:0]        n_num;
    logic [8:0]         r_q0;
    logic [17:0]        r_rem;
    logic [17:0]        n_rem;
    logic [7:0]         r_q;
    logic [7:0]         n_q;
    logic signed [24:0] sm_s;
    logic signed [24:0] c_s;
    logic signed [25:0] diff;
    logic [24:0]        q0_prod;
    logic [24:0]        rem_full;
    logic [8:0]         q_sum;

    always_comb begin
        sm_s = $signed({10'd0, i_sm});
        c_s  = $signed({{16{i_c[8]}}, i_c});
        n_p  = sm_s * c_s;

        // lightness term advances beside the product so both belong to one transaction
        diff = $signed({2'b00, r_lt}) - $signed({r_p[24], r_p});
        // clip a negative numerator to zero
        n_num = diff[25] ? 25'd0 : diff[24:0];

        // num>>16 undershoots the quotient by at most three
        q0_prod  = 25'(r_num[24:16]) * 25'(SCALE_SQ);
        rem_full = r_num - q0_prod;
        n_rem    = rem_full[17:0];

        q_sum = r_q0
              + {8'd0, (r_rem >= 18'(SCALE_SQ))}
              + {8'd0, (r_rem >= 18'(2 * SCALE_SQ))}
              + {8'd0, (r_rem >= 18'(3 * SCALE_SQ))};
        n_q = (q_sum > 9'(SCALE)) ? 8'(SCALE) : q_sum[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= n_p;
            r_lt  <= i_lt;
            r_num <= n_num;
            r_q0  <= r_num[24:16];
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_value = r_q;

endmodule

>>> src/hsl_to_rgb_converter.sv
// Channel     | Dir | Handshake          | Payload
// ------------+-----+--------------------+---------------------------
// input       | in  | i_valid / o_stall  | i_data (t_hsl)
// result      | out | o_valid / i_stall  | o_data (t_rgb)
//
// One transaction per clock while no held result is stalled by i_stall.
// An accepted transaction passes the six-stage pipeline (wedge clamp, S*m,
// chroma product, subtract, quotient estimate, correction) to o_valid.
// Reset is synchronous, active low, and clears the stage valid bits only.
// While the output holds a result and i_stall is high, every stage holds.
// Top level of the HSL to RGB converter; depends on hsl2rgb_pkg,
// hsl2rgb_hue_wedge, hsl2rgb_chan and the assertion macro header.
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_defines.svh"

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_hsl i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_rgb o_data
);

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic                  en;

    t_cval       w_c    [3];
    t_cval       r1_c   [3];
    logic [6:0]  r1_m;
    logic [6:0]  n1_m;
    logic [7:0]  r1_s;
    logic [7:0]  r1_l;
    t_cval       r2_c   [3];
    logic [14:0] r2_sm;
    logic [23:0] r2_lt;
    logic [7:0]  chan_q [3];

    assign en      = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    assign n_vld = {r_vld[PIPE_DEPTH-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    hsl2rgb_hue_wedge u_wedge_red (
        .i_hue    (i_data.hue),
        .i_offset (OFFSET_RED),
        .o_c      (w_c[0])
    );

    hsl2rgb_hue_wedge u_wedge_green (
        .i_hue    (i_data.hue),
        .i_offset (OFFSET_GREEN),
        .o_c      (w_c[1])
    );

    hsl2rgb_hue_wedge u_wedge_blue (
        .i_hue    (i_data.hue),
        .i_offset (OFFSET_BLUE),
        .o_c      (w_c[2])
    );

    // distance of lightness from the nearer end
    assign n1_m = i_data.lightness[7] ? 7'(8'(SCALE) - i_data.lightness)
                                      : i_data.lightness[6:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c  <= w_c;
            r1_m  <= n1_m;
            r1_s  <= i_data.saturation;
            r1_l  <= i_data.lightness;
            r2_c  <= r1_c;
            r2_sm <= 15'(r1_s) * 15'(r1_m);
            r2_lt <= 24'(r1_l) * 24'(SCALE_SQ);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_chan
        hsl2rgb_chan u_chan (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_c     (r2_c[g]),
            .i_sm    (r2_sm),
            .i_lt    (r2_lt),
            .o_value (chan_q[g])
        );
    end

    assign o_data.red   = chan_q[0];
    assign o_data.green = chan_q[1];
    assign o_data.blue  = chan_q[2];

    `ASSERT_IMPL(a_stall_when_held, o_valid && i_stall, o_stall, "pipeline not held on output stall")
    `ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_vld[0], "accepted transaction lost at entry")
    `ASSERT_NEXT(a_hold_keeps_valid, r_vld[PIPE_DEPTH-1] && i_stall, o_valid, "held result dropped")
    `ASSERT_ALWAYS_NEXT(a_reset_clears, !i_rst_n, !o_valid, "output valid after reset")

endmodule
